// ===== rtl/su2_gauge_relaxation_site_macros.svh =====
// Assertion macros for the SU(2) relaxation site checker
`ifndef SU2_GAUGE_RELAXATION_SITE_MACROS_SVH
`define SU2_GAUGE_RELAXATION_SITE_MACROS_SVH

// same-cycle implication
`define SU2_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("su2grs: same-cycle check failed");

// next-cycle implication
`define SU2_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("su2grs: next-cycle check failed");

`endif

// ===== rtl/su2grs_pkg.sv =====
// Constants, types and tables for the SU(2) gauge relaxation site
package su2grs_pkg;

   localparam int unsigned EXTENT_X = 8;
   localparam int unsigned EXTENT_Y = 8;
   localparam int unsigned EXTENT_Z = 8;
   localparam int unsigned EXTENT_T = 8;
   localparam int unsigned SITE_COUNT = EXTENT_X * EXTENT_Y * EXTENT_Z * EXTENT_T;
   localparam int unsigned STORE_SITES = 4096;
   localparam int unsigned LINK_DEPTH = STORE_SITES * 4;

   localparam int SITE_W = 12;
   localparam int NIDX_W = 25;
   localparam int COORD_W = 6;
   localparam int EXT_W = 7;
   localparam int ACC_W = 38;
   localparam int MAG_W = 36;
   localparam int MUL_W = 31;
   localparam int PROD_W = 62;
   localparam int DIV_W = 46;
   localparam int QUO_W = 15;
   localparam int SQ_W = 63;
   localparam int DOT_W = 34;
   localparam int CHANGE_W = 15;
   localparam int TOTAL_W = 27;

   localparam logic [2:0] MODE_WRITE_LINK = 3'd0;
   localparam logic [2:0] MODE_WRITE_SITE = 3'd1;
   localparam logic [2:0] MODE_READ_SITE = 3'd2;
   localparam logic [2:0] MODE_RELAX = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;

   localparam logic [CHANGE_W-1:0] CHANGE_MAX = 15'd32767;
   localparam logic [TOTAL_W:0] TOTAL_MAX = 28'd134217727;

   typedef logic [NIDX_W-1:0] nidx_type;

   typedef struct packed {
      logic       neg;
      logic [1:0] a_sel;
      logic [1:0] b_sel;
   } term_type;

   function automatic logic [EXT_W-1:0] extent_of(input logic [1:0] mu);
      logic [EXT_W-1:0] e;
      unique case (mu)
         2'd0: e = EXT_W'(EXTENT_X);
         2'd1: e = EXT_W'(EXTENT_Y);
         2'd2: e = EXT_W'(EXTENT_Z);
         2'd3: e = EXT_W'(EXTENT_T);
      endcase
      return e;
   endfunction

   function automatic nidx_type stride_of(input logic [1:0] mu);
      nidx_type s;
      unique case (mu)
         2'd0: s = NIDX_W'(1);
         2'd1: s = NIDX_W'(EXTENT_X);
         2'd2: s = NIDX_W'(EXTENT_X * EXTENT_Y);
         2'd3: s = NIDX_W'(EXTENT_X * EXTENT_Y * EXTENT_Z);
      endcase
      return s;
   endfunction

   function automatic nidx_type span_of(input logic [1:0] mu);
      nidx_type s;
      unique case (mu)
         2'd0: s = NIDX_W'(EXTENT_X - 1);
         2'd1: s = NIDX_W'((EXTENT_Y - 1) * EXTENT_X);
         2'd2: s = NIDX_W'((EXTENT_Z - 1) * EXTENT_X * EXTENT_Y);
         2'd3: s = NIDX_W'((EXTENT_T - 1) * EXTENT_X * EXTENT_Y * EXTENT_Z);
      endcase
      return s;
   endfunction

   // product terms of the forward and backward neighbour contributions
   function automatic term_type mac_term(input logic bwd, input logic [1:0] comp,
                                         input logic [1:0] step);
      term_type t;
      unique case ({bwd, comp, step})
         5'b0_00_00: t = '{1'b0, 2'd0, 2'd0};
         5'b0_00_01: t = '{1'b0, 2'd1, 2'd1};
         5'b0_00_10: t = '{1'b0, 2'd2, 2'd2};
         5'b0_00_11: t = '{1'b0, 2'd3, 2'd3};
         5'b0_01_00: t = '{1'b1, 2'd0, 2'd1};
         5'b0_01_01: t = '{1'b0, 2'd1, 2'd0};
         5'b0_01_10: t = '{1'b1, 2'd3, 2'd2};
         5'b0_01_11: t = '{1'b0, 2'd2, 2'd3};
         5'b0_10_00: t = '{1'b1, 2'd0, 2'd2};
         5'b0_10_01: t = '{1'b0, 2'd2, 2'd0};
         5'b0_10_10: t = '{1'b1, 2'd1, 2'd3};
         5'b0_10_11: t = '{1'b0, 2'd3, 2'd1};
         5'b0_11_00: t = '{1'b1, 2'd0, 2'd3};
         5'b0_11_01: t = '{1'b0, 2'd3, 2'd0};
         5'b0_11_10: t = '{1'b1, 2'd2, 2'd1};
         5'b0_11_11: t = '{1'b0, 2'd1, 2'd2};
         5'b1_00_00: t = '{1'b0, 2'd0, 2'd0};
         5'b1_00_01: t = '{1'b1, 2'd1, 2'd1};
         5'b1_00_10: t = '{1'b1, 2'd2, 2'd2};
         5'b1_00_11: t = '{1'b1, 2'd3, 2'd3};
         5'b1_01_00: t = '{1'b0, 2'd3, 2'd2};
         5'b1_01_01: t = '{1'b1, 2'd2, 2'd3};
         5'b1_01_10: t = '{1'b1, 2'd1, 2'd0};
         5'b1_01_11: t = '{1'b1, 2'd0, 2'd1};
         5'b1_10_00: t = '{1'b0, 2'd1, 2'd3};
         5'b1_10_01: t = '{1'b1, 2'd3, 2'd1};
         5'b1_10_10: t = '{1'b1, 2'd2, 2'd0};
         5'b1_10_11: t = '{1'b1, 2'd0, 2'd2};
         5'b1_11_00: t = '{1'b0, 2'd2, 2'd1};
         5'b1_11_01: t = '{1'b1, 2'd1, 2'd2};
         5'b1_11_10: t = '{1'b1, 2'd3, 2'd0};
         5'b1_11_11: t = '{1'b1, 2'd0, 2'd3};
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/su2_gauge_relaxation_site.sv =====
// SU(2) gauge relaxation site: link and transform stores with a sequenced relax datapath
//
// One word is taken at a time; req_ready is high only when the block is idle and no
// result word is waiting. Link writes, site writes, site reads and statistics clears
// pass through the write, read and output states before rsp_valid. A relax finds
// the site coordinates by three divisions on the bit-serial divider, forms the eight
// neighbour terms (a read of each store and 16 products each on the single shared
// 31x31 multiplier), normalizes them by shifts and, unless all are zero, runs the
// squared norm, the bit-serial square root, four rounded divisions and change measure.
// Stores power up undefined; read only entries that were written.
module su2_gauge_relaxation_site (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_mode,
   input  logic [11:0]                           req_site,
   input  logic [1:0]                            req_direction,
   input  logic signed [15:0]                    req_in_q0,
   input  logic signed [15:0]                    req_in_q1,
   input  logic signed [15:0]                    req_in_q2,
   input  logic signed [15:0]                    req_in_q3,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [15:0]                    rsp_out_q0,
   output logic signed [15:0]                    rsp_out_q1,
   output logic signed [15:0]                    rsp_out_q2,
   output logic signed [15:0]                    rsp_out_q3,
   output logic [su2grs_pkg::CHANGE_W-1:0]       rsp_change,
   output logic [su2grs_pkg::CHANGE_W-1:0]       rsp_largest_change,
   output logic [su2grs_pkg::TOTAL_W-1:0]        rsp_change_total,
   output logic                                  rsp_degenerate
);
   import su2grs_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_WRITE  = 4'd1;
   localparam logic [3:0] ST_DIV    = 4'd2;
   localparam logic [3:0] ST_GREAD  = 4'd3;
   localparam logic [3:0] ST_FETCH  = 4'd4;
   localparam logic [3:0] ST_MAC    = 4'd5;
   localparam logic [3:0] ST_DRAIN  = 4'd6;
   localparam logic [3:0] ST_NORM   = 4'd7;
   localparam logic [3:0] ST_SHIFT  = 4'd8;
   localparam logic [3:0] ST_SQ     = 4'd9;
   localparam logic [3:0] ST_SQRT   = 4'd10;
   localparam logic [3:0] ST_DOT    = 4'd11;
   localparam logic [3:0] ST_FINISH = 4'd12;
   localparam logic [3:0] ST_READ   = 4'd13;
   localparam logic [3:0] ST_OUT    = 4'd14;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_MAC  = 2'd1;
   localparam logic [1:0] OP_SQ   = 2'd2;
   localparam logic [1:0] OP_DOT  = 2'd3;

   // control
   logic [3:0]  state_ff, state_in;
   logic [5:0]  cnt_ff;
   logic [1:0]  idx_ff;
   logic [2:0]  term_ff;
   logic        div_comp_ff;
   logic [1:0]  mul_op_ff;
   logic        rsp_valid_ff;
   logic [CHANGE_W-1:0] max_ff;
   logic [TOTAL_W-1:0]  sum_ff;

   // request word
   logic [2:0]        mode_ff;
   logic [SITE_W-1:0] site_ff;
   logic [1:0]        dir_ff;
   logic [63:0]       wq_ff;
   logic              site_ok_ff;

   // datapath
   logic [COORD_W-1:0]      c_ff [4];
   logic [QUO_W-1:0]        rem_ff;
   logic [63:0]             lrd_ff, trd_ff;
   logic                    lzero_ff, tzero_ff;
   logic signed [15:0]      g_ff [4];
   logic signed [ACC_W-1:0] acc_ff [4];
   logic signed [PROD_W-1:0] prod_ff;
   logic [1:0]              mul_idx_ff;
   logic                    mul_neg_ff;
   logic [MAG_W-1:0]        mag_ff [4];
   logic                    neg_ff [4];
   logic [MAG_W-1:0]        m_ff;
   logic [SQ_W-1:0]         n2_ff, res_ff, bit_ff;
   logic [DIV_W-1:0]        div_n_ff, div_d_ff;
   logic [QUO_W-1:0]        div_q_ff;
   logic signed [15:0]      t_ff [4];
   logic signed [DOT_W-1:0] dot_ff;
   logic [CHANGE_W-1:0]     change_ff;
   logic                    degen_ff;
   logic [63:0]             out_q_ff;

   // memories
   logic [63:0] link_mem [LINK_DEPTH];
   logic [63:0] trans_mem [STORE_SITES];

   logic        l_we, l_re, t_we, t_re;
   logic [SITE_W+1:0] l_waddr, l_raddr;
   logic [SITE_W-1:0] t_raddr;
   logic [63:0] t_wdata;

   logic            accept;
   logic            site_ok;
   logic            last_cnt;

   // neighbour addressing
   logic [1:0]       f_mu;
   logic             f_bwd;
   logic [COORD_W-1:0] f_c;
   logic [EXT_W-1:0] f_ext;
   nidx_type         f_site, f_nidx;
   logic             f_over;

   // multiplier
   term_type                 mterm;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic [1:0]               mul_op_in;
   logic [1:0]               mul_idx_in;
   logic                     mul_neg_in;

   // divider step
   logic             div_ge;
   logic [DIV_W-1:0] div_n_in;
   logic [QUO_W-1:0] div_q_in;

   // square root step
   logic [SQ_W-1:0]  sq_sum;
   logic             sq_ge;

   // normalize
   logic [MAG_W-1:0] abs_v [4];
   logic [MAG_W-1:0] max01, max23, max_all;

   // finish
   logic signed [DOT_W:0] d_val, d_plus;
   logic [20:0]           d_sh;
   logic [CHANGE_W-1:0]   q_val;
   logic [TOTAL_W:0]      sum_wide;
   logic signed [15:0]    v16;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign site_ok   = (NIDX_W'(req_site) < NIDX_W'(SITE_COUNT));

   // neighbour index of the current term
   assign f_mu   = term_ff[2:1];
   assign f_bwd  = term_ff[0];
   assign f_c    = c_ff[f_mu];
   assign f_ext  = extent_of(f_mu);
   assign f_site = NIDX_W'(site_ff);
   always_comb begin
      if (!f_bwd) begin
         if ({1'b0, f_c} == f_ext - EXT_W'(1)) f_nidx = f_site - span_of(f_mu);
         else                                   f_nidx = f_site + stride_of(f_mu);
      end else begin
         if (f_c == '0) f_nidx = f_site + span_of(f_mu);
         else           f_nidx = f_site - stride_of(f_mu);
      end
   end
   assign f_over = (f_nidx[NIDX_W-1:SITE_W] != '0);

   // memory ports
   always_comb begin
      l_we    = (state_ff == ST_WRITE) && (mode_ff == MODE_WRITE_LINK) && site_ok_ff;
      l_waddr = {site_ff, dir_ff};
      l_re    = (state_ff == ST_FETCH);
      l_raddr = {(f_bwd ? f_nidx[SITE_W-1:0] : site_ff), f_mu};
      t_we    = ((state_ff == ST_WRITE) && (mode_ff == MODE_WRITE_SITE) && site_ok_ff)
                || (state_ff == ST_FINISH);
      t_wdata = (state_ff == ST_FINISH) ? {t_ff[3], t_ff[2], t_ff[1], t_ff[0]} : wq_ff;
      t_re    = (state_ff == ST_GREAD) || (state_ff == ST_FETCH) || (state_ff == ST_READ);
      t_raddr = (state_ff == ST_FETCH) ? f_nidx[SITE_W-1:0] : site_ff;
   end

   always_ff @(posedge clock) begin
      if (l_we) link_mem[l_waddr] <= wq_ff;
      if (l_re) lrd_ff <= link_mem[l_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) trans_mem[site_ff] <= t_wdata;
      if (t_re) trd_ff <= trans_mem[t_raddr];
   end

   // shared multiplier operand select
   always_comb begin
      mterm      = mac_term(term_ff[0], cnt_ff[3:2], cnt_ff[1:0]);
      mul_a      = '0;
      mul_b      = '0;
      mul_op_in  = OP_NONE;
      mul_idx_in = cnt_ff[1:0];
      mul_neg_in = 1'b0;
      unique case (state_ff)
         ST_MAC: begin
            mul_op_in  = OP_MAC;
            mul_idx_in = cnt_ff[3:2];
            mul_neg_in = mterm.neg;
            mul_a = lzero_ff ? '0 : MUL_W'($signed(lrd_ff[{mterm.a_sel, 4'b0} +: 16]));
            mul_b = tzero_ff ? '0 : MUL_W'($signed(trd_ff[{mterm.b_sel, 4'b0} +: 16]));
         end
         ST_SQ: begin
            if (!cnt_ff[2]) begin
               mul_op_in = OP_SQ;
               mul_a = $signed({1'b0, mag_ff[cnt_ff[1:0]][29:0]});
               mul_b = $signed({1'b0, mag_ff[cnt_ff[1:0]][29:0]});
            end
         end
         ST_DOT: begin
            if (!cnt_ff[2]) begin
               mul_op_in = OP_DOT;
               mul_a = MUL_W'(g_ff[cnt_ff[1:0]]);
               mul_b = MUL_W'(t_ff[cnt_ff[1:0]]);
            end
         end
         default: ;
      endcase
   end

   // divider step
   assign div_ge   = (div_n_ff >= div_d_ff);
   assign div_n_in = div_ge ? (div_n_ff - div_d_ff) : div_n_ff;
   assign div_q_in = {div_q_ff[QUO_W-2:0], div_ge};

   // square root step
   assign sq_sum = res_ff + bit_ff;
   assign sq_ge  = (n2_ff >= sq_sum);

   // magnitudes
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         abs_v[i] = acc_ff[i][ACC_W-1] ? MAG_W'(-acc_ff[i]) : MAG_W'(acc_ff[i]);
      end
      max01   = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
      max23   = (abs_v[2] > abs_v[3]) ? abs_v[2] : abs_v[3];
      max_all = (max01 > max23) ? max01 : max23;
   end

   // change measure
   always_comb begin
      d_val  = (DOT_W + 1)'(35'sd268435456) - (DOT_W + 1)'(dot_ff);
      d_plus = d_val + (DOT_W + 1)'(35'sd8192);
      d_sh   = d_plus[DOT_W-1:14];
      if (d_val <= 0)                    q_val = '0;
      else if (d_sh > 21'(CHANGE_MAX))  q_val = CHANGE_MAX;
      else                               q_val = d_sh[CHANGE_W-1:0];
      sum_wide = {1'b0, sum_ff} + (TOTAL_W + 1)'(q_val);
      v16 = $signed({1'b0, div_q_in});
   end

   assign last_cnt = (cnt_ff == 6'd15);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ((req_mode == MODE_RELAX) && site_ok) ? ST_DIV : ST_WRITE;
         end
         ST_WRITE: state_in = ST_READ;
         ST_DIV: begin
            if (last_cnt) begin
               if (!div_comp_ff && idx_ff == 2'd2) state_in = ST_GREAD;
               else if (div_comp_ff && idx_ff == 2'd3) state_in = ST_DOT;
            end
         end
         ST_GREAD: state_in = ST_FETCH;
         ST_FETCH: state_in = ST_MAC;
         ST_MAC: begin
            if (last_cnt) state_in = (term_ff == 3'd7) ? ST_DRAIN : ST_FETCH;
         end
         ST_DRAIN: state_in = ST_NORM;
         ST_NORM:  state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (m_ff == '0) state_in = ST_READ;
            else if (m_ff[MAG_W-1:30] == '0 && m_ff[29]) state_in = ST_SQ;
         end
         ST_SQ:   if (cnt_ff == 6'd4) state_in = ST_SQRT;
         ST_SQRT: if (cnt_ff == 6'd31) state_in = ST_DIV;
         ST_DOT:  if (cnt_ff == 6'd4) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_READ;
         ST_READ:   state_in = ST_OUT;
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         term_ff      <= '0;
         div_comp_ff  <= 1'b0;
         mul_op_ff    <= OP_NONE;
         rsp_valid_ff <= 1'b0;
         max_ff       <= '0;
         sum_ff       <= '0;
      end else begin
         state_ff  <= state_in;
         mul_op_ff <= mul_op_in;
         if (state_in != state_ff) cnt_ff <= '0;
         else if (state_ff == ST_DIV && last_cnt) cnt_ff <= '0;
         else if (state_ff == ST_MAC || state_ff == ST_SQ || state_ff == ST_SQRT
                  || state_ff == ST_DOT || state_ff == ST_DIV) cnt_ff <= cnt_ff + 6'd1;
         if (accept) begin
            idx_ff      <= '0;
            div_comp_ff <= 1'b0;
         end
         if (state_ff == ST_DIV && last_cnt) idx_ff <= idx_ff + 2'd1;
         if (state_ff == ST_SQRT) begin
            idx_ff      <= '0;
            div_comp_ff <= 1'b1;
         end
         if (state_ff == ST_GREAD) term_ff <= '0;
         if (state_ff == ST_MAC && last_cnt) term_ff <= term_ff + 3'd1;
         if (state_ff == ST_WRITE && mode_ff == MODE_CLEAR) begin
            max_ff <= '0;
            sum_ff <= '0;
         end
         if (state_ff == ST_FINISH) begin
            if (q_val > max_ff) max_ff <= q_val;
            sum_ff <= (sum_wide > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum_wide[TOTAL_W-1:0];
         end
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         site_ff    <= req_site;
         dir_ff     <= req_direction;
         wq_ff      <= {req_in_q3, req_in_q2, req_in_q1, req_in_q0};
         site_ok_ff <= site_ok;
         rem_ff     <= QUO_W'(req_site);
         change_ff  <= '0;
         degen_ff   <= 1'b0;
      end

      prod_ff    <= mul_a * mul_b;
      mul_idx_ff <= mul_idx_in;
      mul_neg_ff <= mul_neg_in;

      if (state_ff == ST_GREAD) begin
         for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
      end else if (mul_op_ff == OP_MAC) begin
         acc_ff[mul_idx_ff] <= mul_neg_ff ? acc_ff[mul_idx_ff] - ACC_W'(prod_ff)
                                          : acc_ff[mul_idx_ff] + ACC_W'(prod_ff);
      end

      // shared divider: a load, then 15 restoring steps
      if (state_ff == ST_DIV) begin
         if (cnt_ff == '0) begin
            div_q_ff <= '0;
            if (div_comp_ff) begin
               div_n_ff <= {2'b0, mag_ff[idx_ff][29:0], 14'b0} + DIV_W'(res_ff[30:1]);
               div_d_ff <= {1'b0, res_ff[30:0], 14'b0};
            end else begin
               div_n_ff <= DIV_W'(rem_ff);
               div_d_ff <= {25'b0, extent_of(idx_ff), 14'b0};
            end
         end else begin
            div_n_ff <= div_n_in;
            div_q_ff <= div_q_in;
            div_d_ff <= div_d_ff >> 1;
         end
         if (last_cnt) begin
            if (div_comp_ff) begin
               if (idx_ff == 2'd0) t_ff[idx_ff] <= neg_ff[idx_ff] ? -v16 : v16;
               else                t_ff[idx_ff] <= neg_ff[idx_ff] ? v16 : -v16;
            end else begin
               c_ff[idx_ff] <= div_n_in[COORD_W-1:0];
               rem_ff       <= div_q_in;
               if (idx_ff == 2'd2) c_ff[3] <= div_q_in[COORD_W-1:0];
            end
         end
      end

      if (state_ff == ST_FETCH) begin
         lzero_ff <= f_bwd && f_over;
         tzero_ff <= f_over;
         if (term_ff == 3'd0) begin
            for (int i = 0; i < 4; i++) g_ff[i] <= $signed(trd_ff[16*i +: 16]);
         end
      end

      if (state_ff == ST_NORM) begin
         for (int i = 0; i < 4; i++) begin
            mag_ff[i] <= abs_v[i];
            neg_ff[i] <= acc_ff[i][ACC_W-1];
         end
         m_ff <= max_all;
      end

      if (state_ff == ST_SHIFT) begin
         if (m_ff == '0) begin
            degen_ff <= 1'b1;
         end else if (m_ff[MAG_W-1:30] != '0) begin
            for (int i = 0; i < 4; i++) mag_ff[i] <= mag_ff[i] >> 1;
            m_ff <= m_ff >> 1;
         end else if (!m_ff[29]) begin
            for (int i = 0; i < 4; i++) mag_ff[i] <= mag_ff[i] << 1;
            m_ff <= m_ff << 1;
         end else begin
            n2_ff <= '0;
         end
      end

      if (state_ff == ST_SQ) begin
         res_ff <= '0;
         bit_ff <= {1'b1, {(SQ_W - 1){1'b0}}};
      end
      if (mul_op_ff == OP_SQ) begin
         n2_ff <= n2_ff + SQ_W'(prod_ff);
      end else if (state_ff == ST_SQRT) begin
         if (sq_ge) begin
            n2_ff  <= n2_ff - sq_sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      if (state_ff == ST_DIV && last_cnt && div_comp_ff && idx_ff == 2'd3) dot_ff <= '0;
      else if (mul_op_ff == OP_DOT) dot_ff <= dot_ff + DOT_W'(prod_ff);

      if (state_ff == ST_FINISH) change_ff <= q_val;

      if (state_ff == ST_OUT) out_q_ff <= site_ok_ff ? trd_ff : 64'd0;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_q0         = $signed(out_q_ff[15:0]);
   assign rsp_out_q1         = $signed(out_q_ff[31:16]);
   assign rsp_out_q2         = $signed(out_q_ff[47:32]);
   assign rsp_out_q3         = $signed(out_q_ff[63:48]);
   assign rsp_change         = change_ff;
   assign rsp_largest_change = max_ff;
   assign rsp_change_total   = sum_ff;
   assign rsp_degenerate     = degen_ff;

endmodule

// ===== rtl/su2grs_checker.sv =====
// Port-level checks for the SU(2) gauge relaxation site, bound to the top level
`include "su2_gauge_relaxation_site_macros.svh"

module su2grs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_mode,
   input logic [11:0]        req_site,
   input logic [1:0]         req_direction,
   input logic signed [15:0] req_in_q0,
   input logic signed [15:0] req_in_q1,
   input logic signed [15:0] req_in_q2,
   input logic signed [15:0] req_in_q3,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_out_q0,
   input logic signed [15:0] rsp_out_q1,
   input logic signed [15:0] rsp_out_q2,
   input logic signed [15:0] rsp_out_q3,
   input logic [14:0]        rsp_change,
   input logic [14:0]        rsp_largest_change,
   input logic [26:0]        rsp_change_total,
   input logic               rsp_degenerate
);

   // one word in flight: no new word while a result waits
   `SU2_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready)

   // busy right after an accept
   `SU2_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready && !rsp_valid)

   // a held result stays up
   `SU2_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // degenerate relax reports no change
   `SU2_ASSERT_NOW(a_degen_zero, rsp_valid && rsp_degenerate, rsp_change == 15'd0)

   // running max covers the reported change
   `SU2_ASSERT_NOW(a_max_covers, rsp_valid, rsp_largest_change >= rsp_change)

endmodule

bind su2_gauge_relaxation_site su2grs_checker u_su2grs_checker (.*);
